@@ hw/rtl/thm_pkg.sv @@
// Shared constants and codes for the timer heap manager.
`default_nettype none
package thm_pkg;

    // Default sizing
    localparam int CapacityDef  = 32;
    localparam int IdBitsDef    = 10;
    localparam int TypeCountDef = 16;

    // Field widths
    localparam int ModeW   = 2;
    localparam int DurW    = 32;
    localparam int KindW   = 4;
    localparam int IdW     = 10;
    localparam int TimeW   = 48;
    localparam int StatusW = 3;
    localparam int MaskW   = 16;

    // Most fired results per tick transaction
    localparam int MaxRes  = 32;
    localparam int ResCntW = 6;

    // Input modes
    localparam logic [ModeW-1:0] MODE_CREATE  = 2'd0;
    localparam logic [ModeW-1:0] MODE_RELEASE = 2'd1;
    localparam logic [ModeW-1:0] MODE_TICK    = 2'd2;

    // Result status codes
    localparam logic [StatusW-1:0] ST_CREATED  = 3'd0;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
    localparam logic [StatusW-1:0] ST_RELEASED = 3'd2;
    localparam logic [StatusW-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [StatusW-1:0] ST_FIRED    = 3'd4;
    localparam logic [StatusW-1:0] ST_NONE     = 3'd5;

endpackage
`default_nettype wire

@@ hw/rtl/thm_if.sv @@
// Valid/ready channel interfaces for timer requests and results.
`default_nettype none
interface thm_in_if;
    logic                           valid;
    logic                           ready;
    logic [thm_pkg::ModeW-1:0]      mode;
    logic [thm_pkg::DurW-1:0]       duration_ms;
    logic [thm_pkg::KindW-1:0]      kind;
    logic [thm_pkg::IdW-1:0]        target_id;
    logic [thm_pkg::TimeW-1:0]      now_ms;

    modport source (output valid, mode, duration_ms, kind, target_id, now_ms, input ready);
    modport sink   (input valid, mode, duration_ms, kind, target_id, now_ms, output ready);
endinterface

interface thm_out_if;
    logic                           valid;
    logic                           ready;
    logic [thm_pkg::StatusW-1:0]    status;
    logic [thm_pkg::IdW-1:0]        out_id;
    logic [thm_pkg::KindW-1:0]      out_kind;
    logic                           last;

    modport source (output valid, status, out_id, out_kind, last, input ready);
    modport sink   (input valid, status, out_id, out_kind, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/timer_heap_manager_unit.sv @@
// Timer table with a deadline-ordered min-heap held in one synchronous memory.
//
// One request transaction is worked at a time; ready is high only while the unit is
// idle. All timer entries live in one heap memory (deadline, id, type, slot) with a
// registered read, one read and one write per cycle. A create scans the live entries
// for an id clash for each id tried, then sifts the new entry up the heap. A release
// is a scan of the live entries. A tick pops each due entry, fired or dropped, and
// closes with the head check and the final result. Up to 32 fired results come out per
// tick, the final one flagged last. Results pass through an output register, so a
// stalled sink only holds the sequencer when a new result is due.
`default_nettype none
module timer_heap_manager_unit #(
    parameter int CAPACITY   = thm_pkg::CapacityDef,
    parameter int ID_BITS    = thm_pkg::IdBitsDef,
    parameter int TYPE_COUNT = thm_pkg::TypeCountDef
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [thm_pkg::MaskW-1:0]    i_cfg_wdata,
    thm_in_if.sink                      i_in,
    thm_out_if.source                   o_out
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = ID_BITS;

    // Sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CR_TRY  = 5'd1;
    localparam logic [4:0] S_SC_RD   = 5'd2;
    localparam logic [4:0] S_SC_CMP  = 5'd3;
    localparam logic [4:0] S_CR_ALOC = 5'd4;
    localparam logic [4:0] S_PU      = 5'd5;
    localparam logic [4:0] S_PU_CMP  = 5'd6;
    localparam logic [4:0] S_TK_RD0  = 5'd7;
    localparam logic [4:0] S_TK_CHK  = 5'd8;
    localparam logic [4:0] S_TK_LAST = 5'd9;
    localparam logic [4:0] S_SD_RDL  = 5'd10;
    localparam logic [4:0] S_SD_RDR  = 5'd11;
    localparam logic [4:0] S_SD_CMP  = 5'd12;
    localparam logic [4:0] S_TK_EMIT = 5'd13;
    localparam logic [4:0] S_TK_END  = 5'd14;
    localparam logic [4:0] S_EMIT    = 5'd15;

    typedef struct packed {
        logic [thm_pkg::TimeW-1:0] dl;
        logic [IW-1:0]             id;
        logic [thm_pkg::KindW-1:0] kind;
        logic [SW-1:0]             slot;
    } t_ent;

    // Heap order: earlier deadline first, then lower id
    function automatic logic f_before(t_ent a, t_ent b);
        return (a.dl < b.dl) || ((a.dl == b.dl) && (a.id < b.id));
    endfunction

    // Control registers
    logic [4:0]                    r_state, n_state;
    logic [thm_pkg::MaskW-1:0]     r_mask;
    logic [CW-1:0]                 r_count, n_count;
    logic [IW-1:0]                 r_ctr, n_ctr;
    logic [CAPACITY-1:0]           r_valid, n_valid;
    logic [CAPACITY-1:0]           r_del, n_del;
    logic                          r_ov, n_ov;
    logic                          r_pv, n_pv;

    // Working registers
    logic [thm_pkg::ModeW-1:0]     r_mode;
    logic [thm_pkg::TimeW-1:0]     r_now;
    logic [thm_pkg::TimeW-1:0]     r_dl;
    logic [thm_pkg::KindW-1:0]     r_kind;
    logic [thm_pkg::IdW-1:0]       r_target;
    logic [CW-1:0]                 r_tries, n_tries;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [SW-1:0]                 r_pos, n_pos;
    t_ent                          r_ent, n_ent;
    t_ent                          r_ch, n_ch;
    logic                          r_hasr, n_hasr;
    logic [thm_pkg::ResCntW-1:0]   r_n, n_n;
    logic                          r_fire, n_fire;
    logic [IW-1:0]                 r_fid, n_fid;
    logic [thm_pkg::KindW-1:0]     r_fkind, n_fkind;
    logic [IW-1:0]                 r_pid, n_pid;
    logic [thm_pkg::KindW-1:0]     r_pkind, n_pkind;
    logic [thm_pkg::StatusW-1:0]   r_res_st, n_res_st;
    logic [thm_pkg::IdW-1:0]       r_res_id, n_res_id;
    logic [thm_pkg::StatusW-1:0]   r_ost;
    logic [thm_pkg::IdW-1:0]       r_oid;
    logic [thm_pkg::KindW-1:0]     r_okind;
    logic                          r_olast;

    // Heap memory
    t_ent                          r_heap [CAPACITY];
    t_ent                          r_rd;
    logic [SW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [SW-1:0]                 wr_addr;
    t_ent                          wr_data;

    // Output load
    logic                          ld_out;
    logic [thm_pkg::StatusW-1:0]   ld_st;
    logic [thm_pkg::IdW-1:0]       ld_id;
    logic [thm_pkg::KindW-1:0]     ld_kind;
    logic                          ld_last;

    logic                          in_acc;
    logic                          out_free;
    logic [thm_pkg::TimeW:0]       dl_sum;
    logic [SW-1:0]                 free_s;
    logic                          free_ok;
    logic [SW+1:0]                 lc;
    logic [SW+1:0]                 rc;
    logic                          kind_en;
    t_ent                          best;
    logic                          best_is_r;
    logic                          best_is_l;

    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_ov || o_out.ready;
    assign dl_sum   = {1'b0, i_in.now_ms} + {{(thm_pkg::TimeW + 1 - thm_pkg::DurW){1'b0}},
                      i_in.duration_ms};
    assign lc       = {1'b0, r_pos, 1'b1};
    assign rc       = lc + 1'b1;
    assign kind_en  = (int'(r_rd.kind) < TYPE_COUNT) && r_mask[r_rd.kind];

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.status   = r_ost;
    assign o_out.out_id   = r_oid;
    assign o_out.out_kind = r_okind;
    assign o_out.last     = r_olast;

    // Lowest free slot
    always_comb begin
        free_s  = '0;
        free_ok = 1'b0;
        for (int j = CAPACITY - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_s  = SW'(j);
                free_ok = 1'b1;
            end
        end
    end

    // Sift-down child pick
    always_comb begin
        best      = r_ent;
        best_is_l = 1'b0;
        best_is_r = 1'b0;
        if (f_before(r_ch, r_ent)) begin
            best      = r_ch;
            best_is_l = 1'b1;
        end
        if (r_hasr && f_before(r_rd, best)) begin
            best      = r_rd;
            best_is_l = 1'b0;
            best_is_r = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ctr    = r_ctr;
        n_valid  = r_valid;
        n_del    = r_del;
        n_ov     = r_ov && !o_out.ready;
        n_pv     = r_pv;
        n_tries  = r_tries;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_ent    = r_ent;
        n_ch     = r_ch;
        n_hasr   = r_hasr;
        n_n      = r_n;
        n_fire   = r_fire;
        n_fid    = r_fid;
        n_fkind  = r_fkind;
        n_pid    = r_pid;
        n_pkind  = r_pkind;
        n_res_st = r_res_st;
        n_res_id = r_res_id;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_ent;
        ld_out   = 1'b0;
        ld_st    = r_res_st;
        ld_id    = r_res_id;
        ld_kind  = '0;
        ld_last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    case (i_in.mode)
                        thm_pkg::MODE_CREATE: begin
                            n_tries = '0;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res_st = thm_pkg::ST_FULL;
                                n_res_id = '0;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_CR_TRY;
                            end
                        end
                        thm_pkg::MODE_RELEASE: n_state = S_SC_RD;
                        thm_pkg::MODE_TICK: begin
                            n_n     = '0;
                            n_pv    = 1'b0;
                            n_state = S_TK_RD0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CR_TRY: begin
                n_ctr   = r_ctr + 1'b1;
                n_idx   = '0;
                n_state = S_SC_RD;
            end
            S_SC_RD: begin
                rd_addr = r_idx[SW-1:0];
                if (r_idx >= r_count) begin
                    if (r_mode == thm_pkg::MODE_CREATE) begin
                        n_state = S_CR_ALOC;
                    end else begin
                        n_res_st = thm_pkg::ST_UNKNOWN;
                        n_res_id = r_target;
                        n_state  = S_EMIT;
                    end
                end else begin
                    n_state = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_SC_RD;
                if (r_mode == thm_pkg::MODE_CREATE) begin
                    if (r_rd.id == r_ctr) begin
                        if (r_tries == CW'(CAPACITY)) begin
                            n_res_st = thm_pkg::ST_FULL;
                            n_res_id = '0;
                            n_state  = S_EMIT;
                        end else begin
                            n_tries = r_tries + 1'b1;
                            n_state = S_CR_TRY;
                        end
                    end
                end else if (32'(r_rd.id) == 32'(r_target)) begin
                    n_del[r_rd.slot] = 1'b1;
                    n_res_st = thm_pkg::ST_RELEASED;
                    n_res_id = r_target;
                    n_state  = S_EMIT;
                end
            end
            S_CR_ALOC: begin
                if (!free_ok) begin
                    n_res_st = thm_pkg::ST_FULL;
                    n_res_id = '0;
                    n_state  = S_EMIT;
                end else begin
                    n_valid[free_s] = 1'b1;
                    n_del[free_s]   = 1'b0;
                    n_ent   = '{dl: r_dl, id: r_ctr, kind: r_kind, slot: free_s};
                    n_pos   = r_count[SW-1:0];
                    n_count = r_count + 1'b1;
                    n_state = S_PU;
                end
            end
            S_PU: begin
                rd_addr = SW'((r_pos - 1'b1) >> 1);
                if (r_pos == '0) begin
                    wr_en    = 1'b1;
                    n_res_st = thm_pkg::ST_CREATED;
                    n_res_id = thm_pkg::IdW'(r_ctr);
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                wr_en = 1'b1;
                if (f_before(r_ent, r_rd)) begin
                    wr_data = r_rd;
                    n_pos   = SW'((r_pos - 1'b1) >> 1);
                    n_state = S_PU;
                end else begin
                    n_res_st = thm_pkg::ST_CREATED;
                    n_res_id = thm_pkg::IdW'(r_ctr);
                    n_state  = S_EMIT;
                end
            end
            S_TK_RD0: begin
                rd_addr = '0;
                if ((r_count == '0) || (r_n == thm_pkg::ResCntW'(thm_pkg::MaxRes))) begin
                    n_state = S_TK_END;
                end else begin
                    n_state = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                rd_addr = SW'(r_count - 1'b1);
                if (r_rd.dl > r_now) begin
                    n_state = S_TK_END;
                end else begin
                    n_fire  = r_valid[r_rd.slot] && !r_del[r_rd.slot] && kind_en;
                    n_fid   = r_rd.id;
                    n_fkind = r_rd.kind;
                    n_valid[r_rd.slot] = 1'b0;
                    n_del[r_rd.slot]   = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = (r_count == CW'(1)) ? S_TK_EMIT : S_TK_LAST;
                end
            end
            S_TK_LAST: begin
                n_ent   = r_rd;
                n_pos   = '0;
                n_state = S_SD_RDL;
            end
            S_SD_RDL: begin
                rd_addr = lc[SW-1:0];
                if (lc < (SW + 2)'(r_count)) begin
                    n_state = S_SD_RDR;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_TK_EMIT;
                end
            end
            S_SD_RDR: begin
                rd_addr = rc[SW-1:0];
                n_ch    = r_rd;
                n_hasr  = rc < (SW + 2)'(r_count);
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                wr_en   = 1'b1;
                wr_data = best;
                if (best_is_r) begin
                    n_pos   = rc[SW-1:0];
                    n_state = S_SD_RDL;
                end else if (best_is_l) begin
                    n_pos   = lc[SW-1:0];
                    n_state = S_SD_RDL;
                end else begin
                    n_state = S_TK_EMIT;
                end
            end
            S_TK_EMIT: begin
                // Hold one fired result back so the final one can be flagged
                if (!r_fire) begin
                    n_state = S_TK_RD0;
                end else if (!r_pv || out_free) begin
                    if (r_pv) begin
                        ld_out  = 1'b1;
                        ld_st   = thm_pkg::ST_FIRED;
                        ld_id   = thm_pkg::IdW'(r_pid);
                        ld_kind = r_pkind;
                        ld_last = 1'b0;
                    end
                    n_pv    = 1'b1;
                    n_pid   = r_fid;
                    n_pkind = r_fkind;
                    n_n     = r_n + 1'b1;
                    n_state = S_TK_RD0;
                end
            end
            S_TK_END: begin
                if (r_pv) begin
                    if (out_free) begin
                        ld_out  = 1'b1;
                        ld_st   = thm_pkg::ST_FIRED;
                        ld_id   = thm_pkg::IdW'(r_pid);
                        ld_kind = r_pkind;
                        n_pv    = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_res_st = thm_pkg::ST_NONE;
                    n_res_id = '0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (ld_out) begin
            n_ov = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
            r_count <= '0;
            r_ctr   <= '0;
            r_valid <= '0;
            r_del   <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ctr   <= n_ctr;
            r_valid <= n_valid;
            r_del   <= n_del;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= i_in.mode;
            r_now    <= i_in.now_ms;
            r_dl     <= dl_sum[thm_pkg::TimeW] ? '1 : dl_sum[thm_pkg::TimeW-1:0];
            r_kind   <= i_in.kind;
            r_target <= i_in.target_id;
        end
        r_tries  <= n_tries;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_ent    <= n_ent;
        r_ch     <= n_ch;
        r_hasr   <= n_hasr;
        r_n      <= n_n;
        r_fire   <= n_fire;
        r_fid    <= n_fid;
        r_fkind  <= n_fkind;
        r_pid    <= n_pid;
        r_pkind  <= n_pkind;
        r_res_st <= n_res_st;
        r_res_id <= n_res_id;
        if (ld_out) begin
            r_ost   <= ld_st;
            r_oid   <= ld_id;
            r_okind <= ld_kind;
            r_olast <= ld_last;
        end
    end

    // Heap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[wr_addr] <= wr_data;
        end
        r_rd <= r_heap[rd_addr];
    end

`ifndef ASSERT_OFF
    // Heap never holds more entries than slots
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count above capacity");

    // At rest, live slots and heap entries agree
    a_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_valid) == int'(r_count)))
        else $error("slot valid bits disagree with heap count");

    // A held fired result implies at least one fire was counted
    a_pend_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_n != '0))
        else $error("pending result without fire count");

    // No new result is loaded over one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> ($stable(r_ost) && $stable(r_oid) && $stable(r_olast)))
        else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire

@@ bench/timer_heap_manager_unit_tb.sv @@
// Self-checking testbench for the timer heap manager: directed cases, then random traffic.
`timescale 1ns / 1ps

module timer_heap_manager_unit_tb;

    localparam int ModeW   = thm_pkg::ModeW;
    localparam int DurW    = thm_pkg::DurW;
    localparam int KindW   = thm_pkg::KindW;
    localparam int IdW     = thm_pkg::IdW;
    localparam int TimeW   = thm_pkg::TimeW;
    localparam int StatusW = thm_pkg::StatusW;
    localparam int MaskW   = thm_pkg::MaskW;
    localparam int MaxRes  = thm_pkg::MaxRes;

    localparam int Slots = 32;
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
    localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [DurW-1:0]   duration_ms;
        logic [KindW-1:0]  kind;
        logic [IdW-1:0]    target_id;
        logic [TimeW-1:0]  now_ms;
    } t_timer_req;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [IdW-1:0]     out_id;
        logic [KindW-1:0]   out_kind;
        logic               last;
    } t_timer_res;

    // Mirror of the timer table and heap; predicts results per accepted transaction
    class thm_scoreboard;
        logic [MaskW-1:0]  type_mask;
        bit                live[Slots];
        bit                dropped[Slots];
        logic [IdW-1:0]    slot_tid[Slots];
        logic [KindW-1:0]  slot_type[Slots];
        logic [TimeW-1:0]  heap_dl[Slots];
        int                heap_sl[Slots];
        int                heap_n;
        logic [IdW-1:0]    next_id;
        t_timer_res        pending_results[$];
        int                errors;

        function new();
            type_mask = '0;
            foreach (live[i]) begin
                live[i] = 0;
                dropped[i] = 0;
            end
            heap_n = 0;
            next_id = '0;
            errors = 0;
        endfunction

        // Ordering: deadline first, then id
        function bit earlier(int a, int b);
            if (heap_dl[a] != heap_dl[b])
                return heap_dl[a] < heap_dl[b];
            return slot_tid[heap_sl[a]] < slot_tid[heap_sl[b]];
        endfunction

        function void swap_heap(int a, int b);
            logic [TimeW-1:0] d;
            int s;
            d = heap_dl[a];
            s = heap_sl[a];
            heap_dl[a] = heap_dl[b];
            heap_sl[a] = heap_sl[b];
            heap_dl[b] = d;
            heap_sl[b] = s;
        endfunction

        function void heap_insert(logic [TimeW-1:0] dl, int slot);
            int i;
            int p;
            i = heap_n;
            heap_n++;
            heap_dl[i] = dl;
            heap_sl[i] = slot;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!earlier(i, p))
                    break;
                swap_heap(i, p);
                i = p;
            end
        endfunction

        function void heap_remove_top();
            int i;
            int l;
            int r;
            int m;
            i = 0;
            heap_n--;
            heap_dl[0] = heap_dl[heap_n];
            heap_sl[0] = heap_sl[heap_n];
            forever begin
                l = 2 * i + 1;
                r = l + 1;
                m = i;
                if (l < heap_n && earlier(l, m))
                    m = l;
                if (r < heap_n && earlier(r, m))
                    m = r;
                if (m == i)
                    break;
                swap_heap(i, m);
                i = m;
            end
        endfunction

        function int slot_of(logic [IdW-1:0] tid);
            foreach (live[s])
                if (live[s] && slot_tid[s] == tid)
                    return s;
            return -1;
        endfunction

        function void add_result(logic [StatusW-1:0] st, logic [IdW-1:0] tid,
                                 logic [KindW-1:0] k, logic lst);
            t_timer_res r;
            r.status = st;
            r.out_id = tid;
            r.out_kind = k;
            r.last = lst;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Any live (or deleted, unpopped) id; random id if the table is empty
        function logic [IdW-1:0] pick_tracked_id();
            int cand[$];
            foreach (live[s])
                if (live[s])
                    cand.insert(cand.size(), s);
            if (cand.size() == 0)
                return IdW'($urandom);
            return slot_tid[cand[$urandom_range(0, cand.size() - 1)]];
        endfunction

        function void note_request(t_timer_req q);
            int s;
            int fired;
            bit found;
            bit en;
            logic [TimeW:0] sum;
            logic [KindW-1:0] k;
            logic [IdW-1:0] tid;
            case (q.mode)
                thm_pkg::MODE_CREATE: begin
                    found = 0;
                    if (heap_n < Slots) begin
                        for (int t = 0; t <= Slots; t++) begin
                            next_id = next_id + 1'b1;
                            if (slot_of(next_id) < 0) begin
                                found = 1;
                                break;
                            end
                        end
                    end
                    s = -1;
                    if (found)
                        foreach (live[i])
                            if (!live[i] && s < 0)
                                s = i;
                    if (s < 0) begin
                        add_result(thm_pkg::ST_FULL, '0, '0, 1'b1);
                    end else begin
                        live[s] = 1;
                        dropped[s] = 0;
                        slot_tid[s] = next_id;
                        slot_type[s] = q.kind;
                        sum = q.now_ms + q.duration_ms;
                        heap_insert(sum > TimeMax ? TimeMax : sum[TimeW-1:0], s);
                        add_result(thm_pkg::ST_CREATED, next_id, '0, 1'b1);
                    end
                end
                thm_pkg::MODE_RELEASE: begin
                    s = slot_of(q.target_id);
                    if (s >= 0) begin
                        dropped[s] = 1;
                        add_result(thm_pkg::ST_RELEASED, q.target_id, '0, 1'b1);
                    end else begin
                        add_result(thm_pkg::ST_UNKNOWN, q.target_id, '0, 1'b1);
                    end
                end
                thm_pkg::MODE_TICK: begin
                    fired = 0;
                    while (heap_n > 0 && fired < MaxRes && heap_dl[0] <= q.now_ms) begin
                        s = heap_sl[0];
                        k = slot_type[s];
                        tid = slot_tid[s];
                        en = type_mask[k];
                        found = live[s] && !dropped[s];
                        heap_remove_top();
                        live[s] = 0;
                        dropped[s] = 0;
                        if (found && en) begin
                            add_result(thm_pkg::ST_FIRED, tid, k, 1'b0);
                            fired++;
                        end
                    end
                    if (fired == 0)
                        add_result(thm_pkg::ST_NONE, '0, '0, 1'b1);
                    else
                        pending_results[$].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_timer_res got);
            t_timer_res want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d id %0d", $time, got.status,
                         got.out_id);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.out_id !== want.out_id) begin
                $display("%0t: out_id expected %0d got %0d", $time, want.out_id, got.out_id);
                errors++;
            end
            if (got.out_kind !== want.out_kind) begin
                $display("%0t: out_kind expected %0d got %0d", $time, want.out_kind,
                         got.out_kind);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MaskW-1:0] i_cfg_wdata;

    thm_in_if  in_ch();
    thm_out_if out_ch();

    timer_heap_manager_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    thm_scoreboard sb = new();
    logic [TimeW-1:0] clock_ms;
    bit no_idle;
    bit long_hold;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        t_timer_res r;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                gap = 400;
                long_hold = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                @(negedge i_clk) out_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            r.status = out_ch.status;
            r.out_id = out_ch.out_id;
            r.out_kind = out_ch.out_kind;
            r.last = out_ch.last;
            sb.check_result(r);
        end
    end

    // Offer one request transaction after a random gap; returns once accepted
    task automatic send_req(t_timer_req q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            @(negedge i_clk) in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.mode <= q.mode;
        in_ch.duration_ms <= q.duration_ms;
        in_ch.kind <= q.kind;
        in_ch.target_id <= q.target_id;
        in_ch.now_ms <= q.now_ms;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(q);
    endtask

    task automatic send_fields(logic [ModeW-1:0] m, logic [DurW-1:0] d, logic [KindW-1:0] k,
                               logic [IdW-1:0] t, logic [TimeW-1:0] n);
        t_timer_req q;
        q.mode = m;
        q.duration_ms = d;
        q.kind = k;
        q.target_id = t;
        q.now_ms = n;
        send_req(q);
    endtask

    // Wait for all results, let the block settle
    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk) in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [MaskW-1:0] m);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk) sb.type_mask = m;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // One random request transaction, mostly around the running clock
    task automatic random_req();
        int pick;
        logic [DurW-1:0] d;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0)
            clock_ms = TimeW'({$urandom, $urandom});
        d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
        if (pick < 45)
            send_fields(thm_pkg::MODE_CREATE, d, KindW'($urandom), IdW'($urandom), clock_ms);
        else if (pick < 65)
            send_fields(thm_pkg::MODE_RELEASE, $urandom, KindW'($urandom),
                        ($urandom_range(0, 3) != 0) ? sb.pick_tracked_id() : IdW'($urandom),
                        TimeW'({$urandom, $urandom}));
        else if (pick < 96) begin
            clock_ms = (clock_ms > TimeMax - 64) ? TimeMax : clock_ms + $urandom_range(0, 40);
            send_fields(thm_pkg::MODE_TICK, $urandom, KindW'($urandom), IdW'($urandom),
                        clock_ms);
        end else
            send_fields(MODE_UNUSED, $urandom, KindW'($urandom), IdW'($urandom),
                        TimeW'({$urandom, $urandom}));
    endtask

    initial begin
        logic [MaskW-1:0] masks[8];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = thm_pkg::MODE_CREATE;
        in_ch.duration_ms = '0;
        in_ch.kind = '0;
        in_ch.target_id = '0;
        in_ch.now_ms = '0;
        no_idle = 0;
        long_hold = 0;
        clock_ms = 1000;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: mask clear after reset drops a due timer
        send_fields(thm_pkg::MODE_CREATE, 0, 3, 0, 100);
        send_fields(thm_pkg::MODE_TICK, 0, 0, 0, 100);
        write_mask(16'hFFFF);
        send_fields(thm_pkg::MODE_CREATE, 0, 0, 0, 0);
        send_fields(thm_pkg::MODE_CREATE, 32'hFFFF_FFFF, 15, 0, TimeMax);
        send_fields(thm_pkg::MODE_CREATE, 5, 7, 0, 0);
        send_fields(thm_pkg::MODE_CREATE, 5, 9, 0, 0);
        send_fields(thm_pkg::MODE_RELEASE, 0, 0, 10'h3FF, 0);
        send_fields(thm_pkg::MODE_RELEASE, 0, 0, 4, 0);
        send_fields(thm_pkg::MODE_RELEASE, 0, 0, 4, 0);
        send_fields(MODE_UNUSED, 32'hFFFF_FFFF, 15, 10'h3FF, TimeMax);
        send_fields(thm_pkg::MODE_TICK, 0, 0, 0, 4);
        send_fields(thm_pkg::MODE_TICK, 0, 0, 0, 5);
        send_fields(thm_pkg::MODE_TICK, 0, 0, 0, TimeMax);
        send_fields(thm_pkg::MODE_TICK, 0, 0, 0, TimeMax);
        // Fill the table past capacity, then fire the whole burst at once
        no_idle = 1;
        for (int i = 0; i < Slots + 1; i++)
            send_fields(thm_pkg::MODE_CREATE, $urandom_range(0, 3), KindW'(i), 0, 50);
        no_idle = 0;
        send_fields(thm_pkg::MODE_TICK, 0, 0, 0, 60);

        // Random phases under several masks
        masks = '{16'h0000, 16'hFFFF, 16'h5555, 16'h8001, 16'hFFFF, 16'hAAAA,
                  MaskW'($urandom), 16'hFFFF};
        for (int ph = 0; ph < 8; ph++) begin
            write_mask(masks[ph]);
            no_idle = (ph == 5);
            if (ph == 2)
                long_hold = 1;
            for (int i = 0; i < 48; i++) begin
                if (ph == 4 && i == 24)
                    drain();
                random_req();
            end
        end
        no_idle = 0;

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
